### rtl/sce_pkg.sv
`default_nettype none

package sce_pkg;

  // Data types of the datapath
  typedef logic signed [63:0] prod_t;  // full product / wide intermediate
  typedef logic signed [31:0] word_t;  // Q.31 working value
  typedef logic signed [32:0] wide_t;  // Q.31 value that may reach +/-1.0
  typedef logic signed [33:0] sel_t;   // after quadrant swap and negate

  // Working formats
  localparam int unsigned WORK_FRAC = 31;
  localparam int unsigned RED_FRAC  = 44;
  localparam int unsigned LO_BITS   = 63 - RED_FRAC;

  // pi/2 in Q1.63, split into a high part (Q.44) and the low bits below it
  localparam logic [63:0] PIO2_Q63 = 64'hC90FDAA22168C234;
  localparam logic [63:0] PIO2_HI  = PIO2_Q63 >> LO_BITS;
  localparam logic [63:0] PIO2_LO  = {45'd0, PIO2_Q63[LO_BITS-1:0]};

  // 2/pi in unsigned Q0.32
  localparam logic [31:0] TWO_OVER_PI_Q32 = 32'hA2F9836E;

  // Minimax coefficients in Q.31
  localparam word_t SIN_K1 = -32'sd357913952;
  localparam word_t SIN_K2 =  32'sd17895698;
  localparam word_t SIN_K3 = -32'sd426088;
  localparam word_t SIN_K4 =  32'sd5918;
  localparam word_t COS_K1 = -32'sd1073741824;
  localparam word_t COS_K2 =  32'sd89478488;
  localparam word_t COS_K3 = -32'sd2982616;
  localparam word_t COS_K4 =  32'sd53261;
  localparam prod_t ONE_W  = 64'sd1 <<< WORK_FRAC;

  // Arithmetic shift right by s (s >= 1), rounding half away from zero.
  // For negative v the bias drops by one, which mirrors rounding on |v|.
  function automatic prod_t rnd_shr(input prod_t v, input int unsigned s);
    prod_t half;
    half = prod_t'(1) <<< (s - 1);
    return (v + half - prod_t'(v[63])) >>> s;
  endfunction

endpackage

`default_nettype wire

### rtl/sine_cosine_evaluator.sv
// Sine and cosine of one angle per beat.
// Slave channel s_axis_*: one beat carries a signed Q7.24 angle in radians
// (fraction bits set by ANGLE_FRAC_BITS). Master channel m_axis_*: one beat
// carries sine and cosine of that angle, each signed with RESULT_FRAC_BITS
// fraction bits and saturated to +/-1.0. Every input beat gives exactly one
// output beat, in order.
// Throughput: one beat per cycle while the receiver does not stall. The
// datapath is an 18-stage pipeline: abs and 2/pi multiply, quadrant
// rounding, pi/2 high/low multiply, residue, then Horner steps where each
// multiply and each round-and-add own a stage, then quadrant swap and
// output rounding with saturation.
// Reset: clears all stage valid bits; the pipeline comes out empty and
// s_axis_tready is high.
// Stall: when m_axis_tready is low the last stage holds its beat; bubbles
// further up still close, so new angles are taken until every stage is full.
// Nothing is lost or repeated.
`default_nettype none

module sine_cosine_evaluator #(
  parameter int unsigned ANGLE_FRAC_BITS  = 24,
  parameter int unsigned RESULT_FRAC_BITS = 30
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] angle
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // [31:0] sine, [63:32] cosine
);
  import sce_pkg::*;

  localparam int unsigned N_STAGES  = 18;
  localparam int unsigned M_W       = 32 - ANGLE_FRAC_BITS;
  localparam int unsigned RED_SHIFT = RED_FRAC - ANGLE_FRAC_BITS;
  localparam int unsigned OUT_SHIFT = WORK_FRAC - RESULT_FRAC_BITS;
  localparam logic [63:0] M_HALF    = 64'd1 << (ANGLE_FRAC_BITS + 31);
  localparam logic [63:0] LO_HALF   = 64'd1 << (LO_BITS - 1);
  localparam prod_t       LIM       = prod_t'(1) <<< RESULT_FRAC_BITS;

  // Round a selected Q.31 value to the output format and clamp to +/-1.0
  function automatic logic [31:0] to_result(input sel_t v);
    prod_t t;
    t = rnd_shr(prod_t'(v), OUT_SHIFT);
    if (t > LIM) t = LIM;
    if (t < -LIM) t = -LIM;
    return t[31:0];
  endfunction

  // Stage valid bits and per-stage load enables
  logic [N_STAGES-1:0] vld_q;
  logic [N_STAGES-1:0] en;

  always_comb begin
    en[N_STAGES-1] = !vld_q[N_STAGES-1] || m_axis_tready;
    for (int i = N_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < N_STAGES; i++) begin
        if (en[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[N_STAGES-1];

  // Range reduction registers
  logic           neg0_q, neg1_q, neg2_q, neg3_q, neg4_q;
  logic [31:0]    mag0_q, mag1_q, mag2_q, mag3_q;
  logic [63:0]    prod1_q;
  logic [M_W-1:0] m2_q;
  logic [63:0]    hi3_q, lo3_q;
  logic [1:0]     q3_q, q4_q, q5_q, q6_q, q7_q, q8_q, q9_q, q10_q, q11_q;
  logic [1:0]     q12_q, q13_q, q14_q, q15_q;
  prod_t          rm4_q;

  // Polynomial registers
  word_t r5_q, r6_q, r7_q, r8_q, r9_q, r10_q, r11_q, r12_q, r13_q, r14_q;
  prod_t rr6_q;
  word_t z7_q, z8_q, z9_q, z10_q, z11_q, z12_q, z13_q;
  prod_t ms8_q, mc8_q, mrz8_q;
  word_t p3s9_q, p3c9_q, rz9_q, rz10_q, rz11_q, rz12_q, rz13_q;
  prod_t ms10_q, mc10_q;
  word_t p2s11_q, p2c11_q;
  prod_t ms12_q, mc12_q;
  word_t p1s13_q, p1c13_q;
  prod_t ms14_q, mc14_q;
  wide_t s15_q, c15_q;
  sel_t  so16_q, co16_q;
  logic [31:0] sin17_q, cos17_q;

  always_ff @(posedge clk_i) begin
    // Stage 0: sign and magnitude of the angle
    if (en[0]) begin
      neg0_q <= s_axis_tdata[31];
      mag0_q <= s_axis_tdata[31] ? (32'd0 - s_axis_tdata) : s_axis_tdata;
    end
    // Stage 1: |angle| * 2/pi
    if (en[1]) begin
      neg1_q  <= neg0_q;
      mag1_q  <= mag0_q;
      prod1_q <= 64'(mag0_q) * 64'(TWO_OVER_PI_Q32);
    end
    // Stage 2: quadrant count, rounded on the magnitude
    if (en[2]) begin
      neg2_q <= neg1_q;
      mag2_q <= mag1_q;
      m2_q   <= M_W'((prod1_q + M_HALF) >> (ANGLE_FRAC_BITS + 32));
    end
    // Stage 3: m times the high and low parts of pi/2
    if (en[3]) begin
      neg3_q <= neg2_q;
      mag3_q <= mag2_q;
      hi3_q  <= 64'(m2_q) * PIO2_HI;
      lo3_q  <= 64'(m2_q) * PIO2_LO;
      q3_q   <= neg2_q ? (2'd0 - m2_q[1:0]) : m2_q[1:0];
    end
    // Stage 4: residue on the magnitude in Q.44
    if (en[4]) begin
      neg4_q <= neg3_q;
      q4_q   <= q3_q;
      rm4_q  <= prod_t'((64'(mag3_q) << RED_SHIFT) - hi3_q
                        - ((lo3_q + LO_HALF) >> LO_BITS));
    end
    // Stage 5: signed residue rounded to Q.31
    if (en[5]) begin
      q5_q <= q4_q;
      r5_q <= word_t'(rnd_shr(neg4_q ? -rm4_q : rm4_q, RED_FRAC - WORK_FRAC));
    end
    // Stage 6: r * r
    if (en[6]) begin
      q6_q  <= q5_q;
      r6_q  <= r5_q;
      rr6_q <= prod_t'(r5_q) * prod_t'(r5_q);
    end
    // Stage 7: z = r^2
    if (en[7]) begin
      q7_q <= q6_q;
      r7_q <= r6_q;
      z7_q <= word_t'(rnd_shr(rr6_q, WORK_FRAC));
    end
    // Stage 8: first Horner products and r * z
    if (en[8]) begin
      q8_q   <= q7_q;
      r8_q   <= r7_q;
      z8_q   <= z7_q;
      ms8_q  <= prod_t'(z7_q) * prod_t'(SIN_K4);
      mc8_q  <= prod_t'(z7_q) * prod_t'(COS_K4);
      mrz8_q <= prod_t'(r7_q) * prod_t'(z7_q);
    end
    // Stage 9: round and add third coefficients
    if (en[9]) begin
      q9_q   <= q8_q;
      r9_q   <= r8_q;
      z9_q   <= z8_q;
      p3s9_q <= word_t'(prod_t'(SIN_K3) + rnd_shr(ms8_q, WORK_FRAC));
      p3c9_q <= word_t'(prod_t'(COS_K3) + rnd_shr(mc8_q, WORK_FRAC));
      rz9_q  <= word_t'(rnd_shr(mrz8_q, WORK_FRAC));
    end
    // Stage 10: z * p3
    if (en[10]) begin
      q10_q  <= q9_q;
      r10_q  <= r9_q;
      z10_q  <= z9_q;
      rz10_q <= rz9_q;
      ms10_q <= prod_t'(z9_q) * prod_t'(p3s9_q);
      mc10_q <= prod_t'(z9_q) * prod_t'(p3c9_q);
    end
    // Stage 11: round and add second coefficients
    if (en[11]) begin
      q11_q   <= q10_q;
      r11_q   <= r10_q;
      z11_q   <= z10_q;
      rz11_q  <= rz10_q;
      p2s11_q <= word_t'(prod_t'(SIN_K2) + rnd_shr(ms10_q, WORK_FRAC));
      p2c11_q <= word_t'(prod_t'(COS_K2) + rnd_shr(mc10_q, WORK_FRAC));
    end
    // Stage 12: z * p2
    if (en[12]) begin
      q12_q  <= q11_q;
      r12_q  <= r11_q;
      z12_q  <= z11_q;
      rz12_q <= rz11_q;
      ms12_q <= prod_t'(z11_q) * prod_t'(p2s11_q);
      mc12_q <= prod_t'(z11_q) * prod_t'(p2c11_q);
    end
    // Stage 13: round and add first coefficients
    if (en[13]) begin
      q13_q   <= q12_q;
      r13_q   <= r12_q;
      z13_q   <= z12_q;
      rz13_q  <= rz12_q;
      p1s13_q <= word_t'(prod_t'(SIN_K1) + rnd_shr(ms12_q, WORK_FRAC));
      p1c13_q <= word_t'(prod_t'(COS_K1) + rnd_shr(mc12_q, WORK_FRAC));
    end
    // Stage 14: (r*z) * p1 for sine, z * p1 for cosine
    if (en[14]) begin
      q14_q  <= q13_q;
      r14_q  <= r13_q;
      ms14_q <= prod_t'(rz13_q) * prod_t'(p1s13_q);
      mc14_q <= prod_t'(z13_q) * prod_t'(p1c13_q);
    end
    // Stage 15: s = r + ..., c = 1 + ...
    if (en[15]) begin
      q15_q <= q14_q;
      s15_q <= wide_t'(prod_t'(r14_q) + rnd_shr(ms14_q, WORK_FRAC));
      c15_q <= wide_t'(ONE_W + rnd_shr(mc14_q, WORK_FRAC));
    end
    // Stage 16: quadrant swap and negate
    if (en[16]) begin
      case (q15_q)
        2'd0: begin
          so16_q <= sel_t'(s15_q);
          co16_q <= sel_t'(c15_q);
        end
        2'd1: begin
          so16_q <= sel_t'(c15_q);
          co16_q <= -sel_t'(s15_q);
        end
        2'd2: begin
          so16_q <= -sel_t'(s15_q);
          co16_q <= -sel_t'(c15_q);
        end
        default: begin
          so16_q <= -sel_t'(c15_q);
          co16_q <= sel_t'(s15_q);
        end
      endcase
    end
    // Stage 17: output rounding and saturation
    if (en[17]) begin
      sin17_q <= to_result(so16_q);
      cos17_q <= to_result(co16_q);
    end
  end

  assign m_axis_tdata = {cos17_q, sin17_q};

endmodule

`default_nettype wire

### rtl/sce_checker.sv
`default_nettype none

module sce_checker #(
  parameter int unsigned RESULT_FRAC_BITS = 30
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [31:0] s_axis_tdata,   // [31:0] angle
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata    // [31:0] sine, [63:32] cosine
);

  localparam logic signed [32:0] LIM = 33'sd1 <<< RESULT_FRAC_BITS;

  logic signed [32:0] sin_w, cos_w;
  logic [31:0]        angle_w;

  assign sin_w   = 33'($signed(m_axis_tdata[31:0]));
  assign cos_w   = 33'($signed(m_axis_tdata[63:32]));
  assign angle_w = s_axis_tdata;

  // A stalled output beat holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // Results never exceed +/-1.0
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> sin_w <= LIM && sin_w >= -LIM && cos_w <= LIM && cos_w >= -LIM)
    else $error("result outside +/-1.0");

  // Input is open whenever the output stage is empty or draining
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input blocked with room in the pipeline");

  // Pipeline is empty once reset has been seen at an edge
  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // No output beat at the first edge after reset release; a waiting angle holds
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(rst_ni) |-> !m_axis_tvalid) and
    (s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && angle_w == $past(angle_w)))
    else $error("output beat right after reset or input beat changed while waiting");

endmodule

bind sine_cosine_evaluator sce_checker #(
  .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
) u_sce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/sine_cosine_evaluator_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the sine/cosine evaluator, predicts each result
// from the accepted angle and compares it with the returned beat.
module sine_cosine_evaluator_checker #(
  parameter int unsigned ANGLE_FRAC_BITS  = 24,
  parameter int unsigned RESULT_FRAC_BITS = 30
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [31:0] s_tdata_i,   // [31:0] angle
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [63:0] m_tdata_i,   // [31:0] sine, [63:32] cosine
  output int               mismatch_cnt_o,
  output int               pending_o
);

  import sce_pkg::*;

  typedef struct packed {
    logic [31:0] angle;
    logic [31:0] sine;
    logic [31:0] cosine;
  } sincos_beat_t;

  localparam int unsigned MAX_PRINTED = 50;

  sincos_beat_t sincos_due[$];
  sincos_beat_t want;

  // Shift right with rounding half away from zero (s >= 1)
  function automatic longint round_away(input longint v, input int unsigned s);
    logic [63:0] mag;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // Q.31 product
  function automatic longint q31_mul(input longint a, input longint b);
    return round_away(a * b, WORK_FRAC);
  endfunction

  // Q.31 to output format, clipped to +/-1.0
  function automatic logic [31:0] to_q_result(input longint v);
    longint lim;
    longint t;
    lim = longint'(1) << RESULT_FRAC_BITS;
    t = round_away(v, WORK_FRAC - RESULT_FRAC_BITS);
    if (t > lim) t = lim;
    else if (t < -lim) t = -lim;
    return t[31:0];
  endfunction

  function automatic sincos_beat_t predict_sincos(input logic [31:0] angle);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] quad;
    logic [63:0] lo_fix;
    logic [1:0]  q;
    longint      red, r, z, p, s, c, so, co;
    sincos_beat_t e;
    neg = angle[31];
    mag = {32'd0, neg ? (32'd0 - angle) : angle};
    // quadrant: |angle| * 2/pi rounded half up on the magnitude
    quad = (mag * {32'd0, TWO_OVER_PI_Q32} + (64'd1 << (ANGLE_FRAC_BITS + 31)))
           >> (ANGLE_FRAC_BITS + 32);
    // residue in Q.44 against the split pi/2
    lo_fix = (quad * PIO2_LO + (64'd1 << (LO_BITS - 1))) >> LO_BITS;
    red = $signed((mag << (RED_FRAC - ANGLE_FRAC_BITS)) - quad * PIO2_HI - lo_fix);
    r = round_away(neg ? -red : red, RED_FRAC - WORK_FRAC);
    q = neg ? (2'd0 - quad[1:0]) : quad[1:0];
    z = q31_mul(r, r);
    // sine: Horner in r^2
    p = SIN_K3 + q31_mul(z, SIN_K4);
    p = SIN_K2 + q31_mul(z, p);
    p = SIN_K1 + q31_mul(z, p);
    s = r + q31_mul(q31_mul(r, z), p);
    // cosine: Horner in r^2
    p = COS_K3 + q31_mul(z, COS_K4);
    p = COS_K2 + q31_mul(z, p);
    p = COS_K1 + q31_mul(z, p);
    c = ONE_W + q31_mul(z, p);
    // quadrant swap and negate
    case (q)
      2'd0: begin so = s;  co = c;  end
      2'd1: begin so = c;  co = -s; end
      2'd2: begin so = -s; co = -c; end
      default: begin so = -c; co = s; end
    endcase
    e.angle  = angle;
    e.sine   = to_q_result(so);
    e.cosine = to_q_result(co);
    return e;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt_o < MAX_PRINTED) $display("%0t ns: %s", $time, msg);
    mismatch_cnt_o++;
  endtask

  // Compare the returned beat first, then queue the new angle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mismatch_cnt_o = 0;
      sincos_due.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (sincos_due.size() == 0) begin
          report_mismatch($sformatf("result beat %h with no angle outstanding", m_tdata_i));
        end else begin
          want = sincos_due.pop_front();
          if (m_tdata_i[31:0] !== want.sine)
            report_mismatch($sformatf("sine of angle %h: got %h, want %h",
                                      want.angle, m_tdata_i[31:0], want.sine));
          if (m_tdata_i[63:32] !== want.cosine)
            report_mismatch($sformatf("cosine of angle %h: got %h, want %h",
                                      want.angle, m_tdata_i[63:32], want.cosine));
        end
      end
      if (s_tvalid_i && s_tready_i) sincos_due.push_back(predict_sincos(s_tdata_i));
      pending_o <= sincos_due.size();
    end
  end

endmodule

### tb/sine_cosine_evaluator_tb.sv
`timescale 1ns / 100ps

module sine_cosine_evaluator_tb;

  localparam int unsigned ANGLE_FRAC_BITS  = 24;
  localparam int unsigned RESULT_FRAC_BITS = 30;
  localparam int unsigned PHASE_ITEMS      = 630;
  localparam int unsigned LONG_HOLD        = 80;
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam longint      QUARTER_PI_Q28   = 64'd210828714;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = 32'd0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [63:0] m_tdata;

  int          mismatch_cnt;
  int          angles_in_flight;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_reqs    = 0;

  // Zero, smallest steps, range ends, multiples of pi/4 and quadrant ties
  logic [31:0] edge_angles [0:21] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h0000_8000, 32'd13176795,  32'd13176794,
    -32'sd13176795, 32'd26353589, -32'sd26353589, 32'd39530384,
    32'd52707179,  32'd79060768,  -32'sd79060768, 32'd105414357,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0100_0000,  32'hFF00_0000,
    32'd2134640790, 32'h7FFF_0000
  };

  sine_cosine_evaluator #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata)
  );

  sine_cosine_evaluator_checker #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) u_sincos_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (angles_in_flight)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

  // Mix of full-range angles, a few radians either side of zero, and
  // angles close to odd and even multiples of pi/4
  function automatic logic [31:0] pick_angle();
    int unsigned kind;
    int unsigned mult;
    logic [31:0] a;
    kind = $urandom_range(9);
    if (kind < 4) return $urandom();
    if (kind < 7) return 32'($urandom_range(32'h07FF_FFFF)) - 32'h0400_0000;
    mult = $urandom_range(162);
    a = 32'((longint'(mult) * QUARTER_PI_Q28) >>> 4) + 32'($urandom_range(64)) - 32'd32;
    if ($urandom_range(1) == 1) a = 32'd0 - a;
    return a;
  endfunction

  // Offer one angle, with random idle cycles ahead of it
  task automatic send_angle(input logic [31:0] angle);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= angle;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (angles_in_flight != 0);
  endtask

  // Receiver: random back-pressure, plus a long hold-off on request
  initial begin
    int unsigned holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_served) begin
        holds_served++;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed angles, back to back
    foreach (edge_angles[k]) send_angle(edge_angles[k]);
    wait_drained();

    // sender mostly busy, receiver often stalls
    src_idle_pct = 8;
    snk_idle_pct = 62;
    repeat (PHASE_ITEMS) send_angle(pick_angle());
    wait_drained();

    // sender often idle, receiver mostly ready
    src_idle_pct = 62;
    snk_idle_pct = 8;
    repeat (PHASE_ITEMS) send_angle(pick_angle());
    wait_drained();

    // no idling; a long receiver hold-off fills the pipeline
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (PHASE_ITEMS / 2) send_angle(pick_angle());
    wait_drained();
    hold_reqs++;
    repeat (PHASE_ITEMS - PHASE_ITEMS / 2) send_angle(pick_angle());
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
